[hw/rtl/mck_pkg.sv]
// Package for the Morse character keyer: sequencer states, divider selectors,
// character range constants and the Morse code table.
// No dependencies; imported by morse_character_keyer_core.
`default_nettype none

package mck_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } mck_state_t;

  // Which timing value the shared divider is working on.
  typedef enum logic [1:0] {
    DIV_UNIT,
    DIV_DAH,
    DIV_TAIL
  } mck_div_sel_t;

  // Speed limits and reset value of the speed register.
  localparam logic [4:0] WPM_MIN   = 5'd10;
  localparam logic [4:0] WPM_MAX   = 5'd30;
  localparam logic [4:0] WPM_RESET = 5'd25;

  // Dividends for one unit, one dah and the closing gap.
  localparam logic [8:0] UNIT_DIVIDEND = 9'd120;
  localparam logic [8:0] DAH_DIVIDEND  = 9'd360;
  localparam logic [8:0] TAIL_DIVIDEND = 9'd240;

  // Character ranges.
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_A         = 8'h41;
  localparam logic [7:0] CH_Z         = 8'h5a;
  localparam logic [7:0] LETTER_BASE  = 8'h36;

  localparam int unsigned TABLE_SIZE = 37;

  // Upper five bits: elements from the top bit (1 = dah); lower three bits:
  // element count. Entry 0 is the slash, then digits, then letters.
  localparam logic [7:0] CODE_TABLE [TABLE_SIZE] = '{
    8'h95,
    8'hfd, 8'h7d, 8'h3d, 8'h1d, 8'h0d, 8'h05, 8'h85, 8'hc5, 8'he5, 8'hf5,
    8'h42, 8'h84, 8'ha4, 8'h83, 8'h01, 8'h24, 8'hc3, 8'h04, 8'h02, 8'h74,
    8'ha3, 8'h44, 8'hc2, 8'h82, 8'he3, 8'h64, 8'hd4, 8'h43, 8'h03, 8'h81,
    8'h23, 8'h14, 8'h63, 8'h94, 8'hb4, 8'hc4
  };

endpackage

`default_nettype wire

[hw/rtl/morse_character_keyer_core.sv]
// Morse character keyer: turns one ASCII character into a run of keying
// periods counted in 10 ms ticks.
// Depends on mck_pkg for states, constants and the code table.
//
// Usage:
//   The slave stream takes one character per transfer: s_tdata[7:0] holds the
//   ASCII code and s_tdata[8] the key line enable. The master stream gives one
//   period per transfer: key line level, sidetone and length in ticks, with
//   m_tuser set for a character that has no code and m_tlast on the final
//   period of the character. The speed register is written through cfg_we and
//   cfg_wdata; values below 10 act as 10 and values above 30 as 30.
//   After a character is accepted, a single shift-and-subtract divider works
//   out the unit, dah and closing gap lengths in turn, six steps each; the
//   first period is offered once the closing gap length has been stored.
//   While the receiver is ready, each period is followed directly by the
//   next, up to 11 periods per character. s_tready stays low from acceptance
//   until the final period has been transferred.
//   When the receiver stalls, the current period is held unchanged.
//   Reset returns the block to idle with no pending output and sets the speed
//   to 25 words per minute.
`default_nettype none

module morse_character_keyer_core
  import mck_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Speed register write port
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  // Character input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] character, [8] drive_output, rest zero
  // Period output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] key_line, [1] sounder, [7:2] duration_ticks
  output logic             m_tuser,   // [0] unsupported
  output logic             m_tlast
);

  // Control state
  mck_state_t   state;
  mck_state_t   state_next;
  logic [4:0]   wpm_reg;

  // Character and divider registers
  logic [7:0]   ch_reg;
  logic         drive_reg;
  logic [4:0]   wpm_eff;
  logic [8:0]   rem;
  logic [4:0]   quo;
  logic [2:0]   step;
  mck_div_sel_t div_sel;
  logic [5:0]   unit_len;
  logic [5:0]   dah_len;
  logic [5:0]   tail_len;

  // Emission registers
  logic         unsup;
  logic [2:0]   elem_left;
  logic [4:0]   code_bits;
  logic         in_gap;

  // Shared divider step and character decode signals
  logic [9:0]   div_shifted;
  logic         div_ge;
  logic [5:0]   div_quot;
  logic [4:0]   wpm_clamped;
  logic         is_space;
  logic         is_digit;
  logic         is_letter;
  logic [7:0]   tbl_offset;
  logic [5:0]   tbl_idx;
  logic [7:0]   tbl_code;
  logic         out_last;
  logic         in_xfer;
  logic         out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // Speed clamped to the supported range.
  always_comb begin
    if (wpm_reg < WPM_MIN) begin
      wpm_clamped = WPM_MIN;
    end else if (wpm_reg > WPM_MAX) begin
      wpm_clamped = WPM_MAX;
    end else begin
      wpm_clamped = wpm_reg;
    end
  end

  // One restoring division step: compare the remainder with the shifted divisor.
  assign div_shifted = {5'd0, wpm_eff} << step;
  assign div_ge      = {1'b0, rem} >= div_shifted;
  assign div_quot    = {quo, div_ge};

  // Character decode and table lookup.
  always_comb begin
    is_space  = (ch_reg == CH_SPACE);
    is_digit  = (ch_reg >= CH_SLASH) && (ch_reg <= CH_NINE);
    is_letter = (ch_reg >= CH_A) && (ch_reg <= CH_Z);
    if (is_letter) begin
      tbl_offset = ch_reg - LETTER_BASE;
    end else begin
      tbl_offset = ch_reg - CH_SLASH;
    end
    tbl_idx  = tbl_offset[5:0];
    tbl_code = (is_digit || is_letter) ? CODE_TABLE[tbl_idx] : 8'h00;
  end

  // The final period is the unsupported marker or the closing gap.
  assign out_last = unsup || (elem_left == 3'd0);

  // Speed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wpm_reg <= WPM_RESET;
    end else if (cfg_we) begin
      wpm_reg <= cfg_wdata;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if ((step == 3'd0) && (div_sel == DIV_TAIL)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_xfer && out_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Handshake and payload outputs.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    m_tdata  = 8'd0;
    m_tuser  = 1'b0;
    m_tlast  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_DIV: begin
        s_tready = 1'b0;
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        m_tlast  = out_last;
        if (unsup) begin
          m_tuser = 1'b1;
        end else if (elem_left == 3'd0) begin
          m_tdata = {tail_len, 2'b00};
        end else if (!in_gap) begin
          m_tdata = {(code_bits[4] ? dah_len : unit_len), 1'b1, drive_reg};
        end else begin
          m_tdata = {unit_len, 2'b00};
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Datapath: capture, shared divider iterations and period sequencing.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          ch_reg    <= s_tdata[7:0];
          drive_reg <= s_tdata[8];
          wpm_eff   <= wpm_clamped;
          rem       <= UNIT_DIVIDEND;
          quo       <= 5'd0;
          step      <= 3'd5;
          div_sel   <= DIV_UNIT;
        end
      end
      ST_DIV: begin
        if (step != 3'd0) begin
          if (div_ge) begin
            rem <= rem - div_shifted[8:0];
          end
          quo  <= div_quot[4:0];
          step <= step - 3'd1;
        end else begin
          // Division finished: store it and start the next one, or after the closing gap load the code.
          step <= 3'd5;
          quo  <= 5'd0;
          unique case (div_sel)
            DIV_UNIT: begin
              unit_len <= div_quot;
              rem      <= DAH_DIVIDEND;
              div_sel  <= DIV_DAH;
            end
            DIV_DAH: begin
              dah_len <= div_quot;
              rem     <= TAIL_DIVIDEND;
              div_sel <= DIV_TAIL;
            end
            DIV_TAIL: begin
              tail_len  <= div_quot;
              unsup     <= !(is_space || is_digit || is_letter);
              elem_left <= tbl_code[2:0];
              code_bits <= tbl_code[7:3];
              in_gap    <= 1'b0;
            end
            default: begin
              div_sel <= DIV_UNIT;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_xfer && !out_last) begin
          if (!in_gap) begin
            in_gap <= 1'b1;
          end else begin
            in_gap    <= 1'b0;
            elem_left <= elem_left - 3'd1;
            code_bits <= {code_bits[3:0], 1'b0};
          end
        end
      end
      default: begin
        in_gap <= 1'b0;
      end
    endcase
  end

  // The block never offers a period while it is taking a character.
  assert property (@(posedge clk) disable iff (rst) !(m_tvalid && s_tready))
    else $error("output valid while input ready");

  // Every keyed or gap period has a non-zero length.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[7:2] != 6'd0))
    else $error("zero-length period");

  // A character without a code yields a single, final period.
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tlast)
    else $error("unsupported result not final");

  // After the final period is transferred the block is ready for a new character.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready after final transfer");

endmodule

`default_nettype wire

[tb/keyer_period_checker.sv]
// Period checker for the Morse character keyer: watches the speed register
// port and both streams, predicts the keying periods of every character taken
// in and compares them with the periods given out. Depends on nothing else.
`timescale 1ns / 1ps

module keyer_period_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,    // [7:0] character, [8] drive_output
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,    // [0] key_line, [1] sounder, [7:2] duration_ticks
  input  logic        m_tuser,    // [0] unsupported
  input  logic        m_tlast,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  localparam logic [4:0] SPEED_AT_RESET = 5'd25;
  localparam int         SLOWEST_WPM    = 10;
  localparam int         FASTEST_WPM    = 30;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] SLASH_CHAR   = 8'h2f;
  localparam logic [7:0] NINE_CHAR    = 8'h39;
  localparam logic [7:0] FIRST_LETTER = 8'h41;
  localparam logic [7:0] LAST_LETTER  = 8'h5a;

  // Element pattern in the top bits (first element highest, 1 = dah) and the
  // element count in the low three bits. Slash first, then digits, then letters.
  localparam logic [7:0] MORSE_CODES [37] = '{
    8'h95,
    8'hfd, 8'h7d, 8'h3d, 8'h1d, 8'h0d, 8'h05, 8'h85, 8'hc5, 8'he5, 8'hf5,
    8'h42, 8'h84, 8'ha4, 8'h83, 8'h01, 8'h24, 8'hc3, 8'h04, 8'h02, 8'h74,
    8'ha3, 8'h44, 8'hc2, 8'h82, 8'he3, 8'h64, 8'hd4, 8'h43, 8'h03, 8'h81,
    8'h23, 8'h14, 8'h63, 8'h94, 8'hb4, 8'hc4
  };

  typedef struct packed {
    logic       key_line;
    logic       sounder;
    logic [5:0] duration_ticks;
    logic       unsupported;
    logic       last;
  } keying_period_t;

  keying_period_t expected_periods [$];
  logic [4:0]     speed_setting;

  // Work out the periods of one character at the current speed.
  task automatic queue_periods(input logic [7:0] character, input logic drive_output);
    int wpm;
    int unit_ticks;
    int dah_ticks;
    int tail_ticks;
    int slot;
    logic [7:0] code;
    keying_period_t p;
    wpm = speed_setting;
    if (wpm < SLOWEST_WPM) wpm = SLOWEST_WPM;
    if (wpm > FASTEST_WPM) wpm = FASTEST_WPM;
    unit_ticks = 120 / wpm;
    dah_ticks  = 360 / wpm;
    tail_ticks = 240 / wpm;
    slot = -1;
    if (character >= SLASH_CHAR && character <= NINE_CHAR) begin
      slot = character - SLASH_CHAR;
    end else if (character >= FIRST_LETTER && character <= LAST_LETTER) begin
      slot = character - FIRST_LETTER + 11;
    end

    if (character == SPACE_CHAR) begin
      // A space is just the closing gap.
      p = '{1'b0, 1'b0, tail_ticks[5:0], 1'b0, 1'b1};
      expected_periods.push_back(p);
    end else if (slot < 0) begin
      // No code for this character: one flagged, empty period.
      p = '{1'b0, 1'b0, 6'd0, 1'b1, 1'b1};
      expected_periods.push_back(p);
    end else begin
      code = MORSE_CODES[slot];
      for (int i = 0; i < code[2:0]; i++) begin
        p = '{drive_output, 1'b1, 6'd0, 1'b0, 1'b0};
        p.duration_ticks = code[7 - i] ? dah_ticks[5:0] : unit_ticks[5:0];
        expected_periods.push_back(p);
        p = '{1'b0, 1'b0, unit_ticks[5:0], 1'b0, 1'b0};
        expected_periods.push_back(p);
      end
      p = '{1'b0, 1'b0, tail_ticks[5:0], 1'b0, 1'b1};
      expected_periods.push_back(p);
    end
  endtask

  // Compare each period given out with the oldest prediction, then take in
  // new characters and register writes seen at this edge.
  always @(posedge clk) begin
    keying_period_t got;
    keying_period_t want;
    if (rst) begin
      speed_setting = SPEED_AT_RESET;
      expected_periods.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[0], m_tdata[1], m_tdata[7:2], m_tuser, m_tlast};
        results_seen++;
        if (expected_periods.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: period with none expected: key=%0b snd=%0b dur=%0d unsup=%0b last=%0b",
                     $realtime, got.key_line, got.sounder, got.duration_ticks,
                     got.unsupported, got.last);
        end else begin
          want = expected_periods.pop_front();
          if (got.key_line !== want.key_line || got.sounder !== want.sounder ||
              got.duration_ticks !== want.duration_ticks ||
              got.unsupported !== want.unsupported || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: period mismatch: expected key=%0b snd=%0b dur=%0d unsup=%0b",
                        " last=%0b, got key=%0b snd=%0b dur=%0d unsup=%0b last=%0b"},
                       $realtime, want.key_line, want.sounder, want.duration_ticks,
                       want.unsupported, want.last, got.key_line, got.sounder,
                       got.duration_ticks, got.unsupported, got.last);
          end
        end
      end
      if (s_tvalid && s_tready) queue_periods(s_tdata[7:0], s_tdata[8]);
      if (cfg_we) speed_setting = cfg_wdata;
    end
    pending = expected_periods.size();
  end

endmodule

[tb/morse_character_keyer_core_test.sv]
// Top of the keyer testbench: clock, reset, character stimulus, speed changes
// and output back-pressure. Depends on morse_character_keyer_core and on
// keyer_period_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module morse_character_keyer_core_test;

  localparam int CYCLE_LIMIT    = 2000000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 50;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 150;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int mismatches;
  int pending;
  int results_seen;
  int cycle_count = 0;
  bit allow_gaps;

  morse_character_keyer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  keyer_period_checker period_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one character and hold it until the transfer, then perhaps idle.
  task automatic send_character(input logic [7:0] character, input logic drive_output);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, drive_output, character};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    gap = 0;
    if (allow_gaps && $urandom_range(0, 99) >= 55) begin
      gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(15, 80);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted period has been taken.
  task automatic drain_periods();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write the speed register while the block is idle.
  task automatic write_speed(input logic [4:0] wpm);
    drain_periods();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= wpm;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: bursty back-pressure, with one long hold-off once output is
  // flowing so that the sender is left waiting on a busy block.
  initial begin
    int stall_left;
    int ready_left;
    int pick;
    bit held_long;
    m_tready   = 1'b0;
    stall_left = 0;
    ready_left = 0;
    held_long  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_long && results_seen >= HOLD_AFTER && s_tvalid) begin
        held_long  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (ready_left > 0) begin
        m_tready <= 1'b1;
        ready_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          ready_left = $urandom_range(50, 200);
          m_tready <= 1'b1;
        end else if (pick < 60) begin
          m_tready <= 1'b1;
        end else if (pick < 92) begin
          stall_left = $urandom_range(0, 2);
          m_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 50);
          m_tready <= 1'b0;
        end
      end
      @(negedge clk);
    end
  end

  // Sender: directed characters at the reset speed, then random phases at
  // a range of speeds, extremes and out-of-range values first.
  initial begin
    logic [7:0] directed [19];
    logic [4:0] wpm;
    logic [7:0] character;
    int pick;
    int slot;

    directed = '{
      " ", "/", "0", "9", "A", "Z", "E", "T", "5", "Q",
      8'h00, 8'hff, 8'h2e, 8'h3a, 8'h40, 8'h5b, "a", 8'h7f, 8'h80
    };
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = 5'd0;
    s_tvalid   = 1'b0;
    s_tdata    = 16'd0;
    allow_gaps = 1'b1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Edges of the table, each gap in the ASCII ranges and both drive levels.
    foreach (directed[i]) send_character(directed[i], i[0]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       wpm = 5'd10;
        1:       wpm = 5'd30;
        2:       wpm = 5'd0;
        3:       wpm = 5'd31;
        4:       wpm = 5'd9;
        default: wpm = 5'($urandom_range(0, 31));
      endcase
      write_speed(wpm);
      allow_gaps = (phase != 1 && phase != 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, let the block run dry mid-phase before going on.
        if (phase == 4 && n == 25) drain_periods();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          character = " ";
        end else if (pick < 75) begin
          slot = $urandom_range(0, 36);
          if (slot == 0) character = "/";
          else if (slot <= 10) character = 8'("0" + slot - 1);
          else character = 8'("A" + slot - 11);
        end else begin
          character = 8'($urandom_range(0, 255));
        end
        send_character(character, 1'($urandom_range(0, 1)));
      end
    end

    drain_periods();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
